@@ rtl/gtcp_pkg.sv @@
package gtcp_pkg;

    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;
    localparam int COST_BITS_DEF  = 12;
    localparam int CFG_BITS       = 6;
    localparam int DIR_BITS       = 3;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_EAST  = 3'd1;
    localparam logic [2:0] DIR_WEST  = 3'd2;
    localparam logic [2:0] DIR_NORTH = 3'd3;
    localparam logic [2:0] DIR_SOUTH = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INIT,
        ST_SELF,
        ST_NREQ,
        ST_NWAIT,
        ST_NEVAL,
        ST_WRITE,
        ST_READ_WAIT,
        ST_READ_DONE,
        ST_RESP
    } state_t;

endpackage

@@ rtl/gtcp_ram.sv @@
module gtcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/grid_turn_cost_path_planner.sv @@
// Grid path planner with a turn penalty.
// Requests enter on the s_ channel (operation, cell_x, cell_y) under valid and
// ready; one result per request leaves on the m_ channel under valid and ready.
// Configuration registers grid_width (index 0) and grid_height (index 1) are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// Operations: clear the blocked map, mark a cell blocked, run from a cell, read
// a cell's cost and back-direction.
// One request is handled at a time. A mark's result passes through the RESP
// state to the output register, a read's through READ_WAIT and READ_DONE. A
// clear sweeps all MAX_WIDTH*MAX_HEIGHT cells of the blocked map. A run first
// writes every cell, then does 2*(w+h) sweeps over w*h cells; each unblocked
// cell steps through SELF, then NREQ, NWAIT and NEVAL per neighbour in the
// grid or NREQ alone per side at its edge, then WRITE (one read port per memory).
// After reset a clearing pass empties all MAX_WIDTH*MAX_HEIGHT cells of the
// blocked map; no request is accepted during it. When the receiver stalls the
// result is held in the output register and no new request is taken until it leaves.
module grid_turn_cost_path_planner #(
    parameter int MAX_WIDTH  = gtcp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gtcp_pkg::MAX_HEIGHT_DEF,
    parameter int COST_BITS  = gtcp_pkg::COST_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [gtcp_pkg::CFG_BITS-1:0]  cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [4:0]                     s_cell_x,
    input  logic [4:0]                     s_cell_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [11:0]                    m_path_cost,
    output logic [2:0]                     m_back_direction,
    output logic                           m_reachable
);

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int AB = XB + YB;
    localparam int DB = gtcp_pkg::DIR_BITS;
    localparam int EB = COST_BITS + DB;
    localparam logic [COST_BITS-1:0] INF = '1;
    localparam logic [COST_BITS-1:0] INF1 = INF - 1'b1;
    localparam logic [XB-1:0] XLAST = XB'(MAX_WIDTH - 1);
    localparam logic [YB-1:0] YLAST = YB'(MAX_HEIGHT - 1);
    localparam int SWB = 10;

    gtcp_pkg::state_t state_reg, state_next;

    logic [gtcp_pkg::CFG_BITS-1:0] width_reg, height_reg;
    logic [XB:0] w_eff;
    logic [YB:0] h_eff;
    logic [1:0]  op_reg;
    logic [4:0]  cx_reg, cy_reg;
    logic [XB-1:0] x_reg;
    logic [YB-1:0] y_reg;
    logic [SWB-1:0] sweep_reg;
    logic [1:0]  k_reg;
    logic [COST_BITS-1:0] my_cost_reg;
    logic [DB-1:0] my_dir_reg;
    logic        changed_reg;
    logic        out_valid_reg;
    logic [11:0] out_cost_reg;
    logic [2:0]  out_dir_reg;
    logic        out_reach_reg;
    logic        start_in_reg;

    logic          b_we, b_wdata, b_rdata;
    logic [AB-1:0] b_waddr, b_raddr;
    logic          c_we;
    logic [AB-1:0] c_waddr, c_raddr;
    logic [EB-1:0] c_wdata, c_rdata;

    logic [AB-1:0] me_addr;
    logic [XB:0]   nx;
    logic [YB:0]   ny;
    logic          n_ok;
    logic [AB-1:0] n_addr;
    logic [2:0]    side;
    logic [COST_BITS:0] cand;
    logic [COST_BITS-1:0] cand_sat, n_cost;
    logic          x_last, y_last, sweep_last, k_last;
    logic          in_grid;

    gtcp_ram #(.WIDTH(1), .DEPTH(1 << AB)) u_blocked (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    gtcp_ram #(.WIDTH(EB), .DEPTH(1 << AB)) u_cost (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    always_comb begin
        if (width_reg == '0) begin
            w_eff = (XB+1)'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = (XB+1)'(MAX_WIDTH);
        end else begin
            w_eff = (XB+1)'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = (YB+1)'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = (YB+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (YB+1)'(height_reg);
        end
    end

    assign me_addr    = {y_reg, x_reg};
    assign x_last     = ({1'b0, x_reg} == w_eff - 1'b1);
    assign y_last     = ({1'b0, y_reg} == h_eff - 1'b1);
    assign sweep_last = (32'(sweep_reg) == 2 * (32'(w_eff) + 32'(h_eff)) - 1);
    assign k_last     = (k_reg == 2'd3);
    assign in_grid    = (32'(cx_reg) < 32'(w_eff)) && (32'(cy_reg) < 32'(h_eff));

    always_comb begin
        nx = {1'b0, x_reg};
        ny = {1'b0, y_reg};
        n_ok = 1'b1;
        side = gtcp_pkg::DIR_EAST;
        case (k_reg)
            2'd0: begin
                nx = {1'b0, x_reg} + 1'b1;
                n_ok = (nx < w_eff);
                side = gtcp_pkg::DIR_EAST;
            end
            2'd1: begin
                nx = {1'b0, x_reg} - 1'b1;
                n_ok = (x_reg != '0);
                side = gtcp_pkg::DIR_WEST;
            end
            2'd2: begin
                ny = {1'b0, y_reg} + 1'b1;
                n_ok = (ny < h_eff);
                side = gtcp_pkg::DIR_NORTH;
            end
            default: begin
                ny = {1'b0, y_reg} - 1'b1;
                n_ok = (y_reg != '0);
                side = gtcp_pkg::DIR_SOUTH;
            end
        endcase
        n_addr = {ny[YB-1:0], nx[XB-1:0]};
    end

    assign n_cost   = c_rdata[EB-1:DB];
    assign cand     = {1'b0, n_cost} + ((side == my_dir_reg) ? 1'b1 : 2'd2);
    assign cand_sat = (cand > {1'b0, INF1}) ? INF1 : cand[COST_BITS-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gtcp_pkg::ST_IDLE: begin
                if (s_valid && !out_valid_reg) begin
                    case (s_operation)
                        gtcp_pkg::OP_CLEAR: state_next = gtcp_pkg::ST_CLEAR;
                        gtcp_pkg::OP_MARK:  state_next = gtcp_pkg::ST_RESP;
                        gtcp_pkg::OP_RUN:   state_next = gtcp_pkg::ST_INIT;
                        default:            state_next = gtcp_pkg::ST_READ_WAIT;
                    endcase
                end
            end
            gtcp_pkg::ST_CLEAR: begin
                if (x_reg == XLAST && y_reg == YLAST) begin
                    state_next = (op_reg == gtcp_pkg::OP_CLEAR) ? gtcp_pkg::ST_RESP
                                                               : gtcp_pkg::ST_IDLE;
                end
            end
            gtcp_pkg::ST_INIT: begin
                if (x_reg == XLAST && y_reg == YLAST) begin
                    state_next = gtcp_pkg::ST_SELF;
                end
            end
            gtcp_pkg::ST_SELF:  state_next = gtcp_pkg::ST_NREQ;
            gtcp_pkg::ST_NREQ: begin
                if (b_rdata && k_reg == 2'd0) begin
                    state_next = gtcp_pkg::ST_WRITE;
                end else if (n_ok) begin
                    state_next = gtcp_pkg::ST_NWAIT;
                end else if (k_last) begin
                    state_next = gtcp_pkg::ST_WRITE;
                end
            end
            gtcp_pkg::ST_NWAIT: state_next = gtcp_pkg::ST_NEVAL;
            gtcp_pkg::ST_NEVAL: begin
                state_next = k_last ? gtcp_pkg::ST_WRITE : gtcp_pkg::ST_NREQ;
            end
            gtcp_pkg::ST_WRITE: begin
                if (sweep_last && x_last && y_last) begin
                    state_next = gtcp_pkg::ST_RESP;
                end else begin
                    state_next = gtcp_pkg::ST_SELF;
                end
            end
            gtcp_pkg::ST_READ_WAIT: state_next = gtcp_pkg::ST_READ_DONE;
            gtcp_pkg::ST_READ_DONE: state_next = gtcp_pkg::ST_IDLE;
            gtcp_pkg::ST_RESP:      state_next = gtcp_pkg::ST_IDLE;
            default:                state_next = gtcp_pkg::ST_IDLE;
        endcase
    end

    // The current cell's blocked bit is tested in the NREQ step when k is 0;
    // the neighbour's blocked bit and cost arrive together in NEVAL.
    always_comb begin
        s_ready = (state_reg == gtcp_pkg::ST_IDLE) && !out_valid_reg;
        b_we    = 1'b0;
        b_waddr = me_addr;
        b_wdata = 1'b0;
        b_raddr = me_addr;
        c_we    = 1'b0;
        c_waddr = me_addr;
        c_wdata = {INF, gtcp_pkg::DIR_NONE};
        c_raddr = me_addr;
        case (state_reg)
            gtcp_pkg::ST_IDLE: begin
                b_we    = s_valid && s_ready && s_operation == gtcp_pkg::OP_MARK
                          && 32'(s_cell_x) < MAX_WIDTH && 32'(s_cell_y) < MAX_HEIGHT;
                b_waddr = {YB'(s_cell_y), XB'(s_cell_x)};
                b_wdata = 1'b1;
                c_raddr = {YB'(s_cell_y), XB'(s_cell_x)};
            end
            gtcp_pkg::ST_CLEAR: begin
                b_we = 1'b1;
            end
            gtcp_pkg::ST_INIT: begin
                c_we = 1'b1;
                if (start_in_reg && x_reg == XB'(cx_reg) && y_reg == YB'(cy_reg)) begin
                    c_wdata = {{COST_BITS{1'b0}}, gtcp_pkg::DIR_NONE};
                end
            end
            gtcp_pkg::ST_SELF: begin
                b_raddr = me_addr;
                c_raddr = me_addr;
            end
            gtcp_pkg::ST_NREQ, gtcp_pkg::ST_NWAIT: begin
                b_raddr = n_addr;
                c_raddr = n_addr;
            end
            gtcp_pkg::ST_WRITE: begin
                c_we    = changed_reg;
                c_wdata = {my_cost_reg, my_dir_reg};
            end
            gtcp_pkg::ST_READ_WAIT: begin
                c_raddr = {YB'(cy_reg), XB'(cx_reg)};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gtcp_pkg::ST_CLEAR;
            op_reg        <= gtcp_pkg::OP_MARK;
            x_reg         <= '0;
            y_reg         <= '0;
            width_reg     <= gtcp_pkg::CFG_BITS'(32);
            height_reg    <= gtcp_pkg::CFG_BITS'(32);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == gtcp_pkg::CFG_WIDTH) begin
                    width_reg <= cfg_data;
                end else begin
                    height_reg <= cfg_data;
                end
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                gtcp_pkg::ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg <= s_operation;
                        cx_reg <= s_cell_x;
                        cy_reg <= s_cell_y;
                        start_in_reg <= (32'(s_cell_x) < 32'(w_eff))
                                        && (32'(s_cell_y) < 32'(h_eff));
                        x_reg <= '0;
                        y_reg <= '0;
                    end
                end
                gtcp_pkg::ST_CLEAR, gtcp_pkg::ST_INIT: begin
                    if (x_reg == XLAST && y_reg == YLAST) begin
                        x_reg     <= '0;
                        y_reg     <= '0;
                        sweep_reg <= '0;
                    end else if (x_reg == XLAST) begin
                        x_reg <= '0;
                        y_reg <= y_reg + 1'b1;
                    end else begin
                        x_reg <= x_reg + 1'b1;
                    end
                end
                gtcp_pkg::ST_SELF: begin
                    k_reg       <= 2'd0;
                    changed_reg <= 1'b0;
                end
                gtcp_pkg::ST_NREQ: begin
                    if (k_reg == 2'd0) begin
                        my_cost_reg  <= n_cost;
                        my_dir_reg   <= c_rdata[DB-1:0];
                    end
                    if (!n_ok && !(b_rdata && k_reg == 2'd0)) begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                gtcp_pkg::ST_NEVAL: begin
                    if (!b_rdata && n_cost != INF && my_cost_reg > cand_sat) begin
                        my_cost_reg <= cand_sat;
                        my_dir_reg  <= side;
                        changed_reg <= 1'b1;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                gtcp_pkg::ST_WRITE: begin
                    if (y_last) begin
                        y_reg <= '0;
                        if (x_last) begin
                            x_reg     <= '0;
                            sweep_reg <= sweep_reg + 1'b1;
                        end else begin
                            x_reg <= x_reg + 1'b1;
                        end
                    end else begin
                        y_reg <= y_reg + 1'b1;
                    end
                end
                gtcp_pkg::ST_READ_DONE: begin
                    out_valid_reg <= 1'b1;
                    if (in_grid) begin
                        out_cost_reg  <= 12'(n_cost);
                        out_dir_reg   <= c_rdata[DB-1:0];
                        out_reach_reg <= (n_cost != INF);
                    end else begin
                        out_cost_reg  <= 12'(INF);
                        out_dir_reg   <= gtcp_pkg::DIR_NONE;
                        out_reach_reg <= 1'b0;
                    end
                end
                gtcp_pkg::ST_RESP: begin
                    out_valid_reg <= 1'b1;
                    out_cost_reg  <= '0;
                    out_dir_reg   <= gtcp_pkg::DIR_NONE;
                    out_reach_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_path_cost      = out_cost_reg;
    assign m_back_direction = out_dir_reg;
    assign m_reachable      = out_reach_reg;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == gtcp_pkg::ST_IDLE && !m_valid))
        else $error("request taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_path_cost))
        else $error("result dropped under stall");
    a_reach_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reachable |-> m_path_cost != 12'(INF))
        else $error("reachable with infinite cost");
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gtcp_pkg::ST_IDLE |-> !c_we)
        else $error("cost memory written while idle");
`endif

endmodule
